/* rtl/core/volume_block_page_table_core_macros.svh */
// Assertion helpers used by the page table back end (vbpt_back).
`ifndef VOLUME_BLOCK_PAGE_TABLE_CORE_MACROS_SVH
`define VOLUME_BLOCK_PAGE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VBPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VBPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/vbpt_pkg.sv */
package vbpt_pkg;

  localparam int BSIZE_W     = 9;
  localparam int COORD_W     = 12;
  localparam int VIDX_W      = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 9'd128;

  // Commands
  localparam logic CMD_MAP    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_Z = 2'd2;

  typedef struct packed {
    logic              command;
    logic [VIDX_W-1:0] virt_x;
    logic [VIDX_W-1:0] virt_y;
    logic [VIDX_W-1:0] virt_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] phys_x;
    logic signed [COORD_W-1:0] phys_y;
    logic signed [COORD_W-1:0] phys_z;
    logic                      is_mapped;
  } out_item_t;

  typedef struct packed {
    logic [BSIZE_W-1:0] x;
    logic [BSIZE_W-1:0] y;
    logic [BSIZE_W-1:0] z;
  } block_size_t;

endpackage

/* rtl/core/vbpt_front.sv */
module vbpt_front #(
  parameter int VIRT_X = 32,
  parameter int VIRT_Y = 32,
  parameter int VIRT_Z = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  vbpt_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output logic [((VIRT_X*VIRT_Y*VIRT_Z > 1) ? $clog2(VIRT_X*VIRT_Y*VIRT_Z) : 1):0] q_wdata,
  output logic               stall
);

  localparam int VIRT_COUNT = VIRT_X * VIRT_Y * VIRT_Z;
  localparam int LIN_W = (VIRT_COUNT > 1) ? $clog2(VIRT_COUNT) : 1;
  localparam int VX_W  = (VIRT_X > 1) ? $clog2(VIRT_X) : 1;
  localparam int VY_W  = (VIRT_Y > 1) ? $clog2(VIRT_Y) : 1;
  localparam int VZ_W  = (VIRT_Z > 1) ? $clog2(VIRT_Z) : 1;

  logic [VX_W-1:0]  vx;
  logic [VY_W-1:0]  vy;
  logic [VZ_W-1:0]  vz;
  logic [LIN_W-1:0] lin;

  logic             valid_r, valid_nxt;
  logic [LIN_W:0]   item_r, item_nxt;

  // Saturate out-of-range indexes to the last block on that axis.
  always_comb begin
    if (32'(in_data.virt_x) >= VIRT_X) vx = VX_W'(VIRT_X - 1);
    else                               vx = VX_W'(in_data.virt_x);
    if (32'(in_data.virt_y) >= VIRT_Y) vy = VY_W'(VIRT_Y - 1);
    else                               vy = VY_W'(in_data.virt_y);
    if (32'(in_data.virt_z) >= VIRT_Z) vz = VZ_W'(VIRT_Z - 1);
    else                               vz = VZ_W'(in_data.virt_z);
    lin = LIN_W'(vx) + LIN_W'(VIRT_X) * (LIN_W'(vy) + LIN_W'(VIRT_Y) * LIN_W'(vz));
  end

  assign q_push  = valid_r && !q_full;
  assign q_wdata = item_r;
  assign stall   = valid_r && q_full;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt = 1'b1;
      item_nxt  = {in_data.command, lin};
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

/* rtl/core/vbpt_queue.sv */
module vbpt_queue #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = vbpt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slots_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) slots_r[wr_ptr_r] <= wdata;
  end

endmodule

/* rtl/core/vbpt_back.sv */
`include "volume_block_page_table_core_macros.svh"

module vbpt_back #(
  parameter int VIRT_COUNT = 32768,
  parameter int PHYS_X = 8,
  parameter int PHYS_Y = 8,
  parameter int PHYS_Z = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [((VIRT_COUNT > 1) ? $clog2(VIRT_COUNT) : 1):0] q_rdata,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  vbpt_pkg::block_size_t bsize,
  output logic                  clearing,
  output logic                  out_valid,
  output vbpt_pkg::out_item_t   out_data
);

  localparam int LIN_W = (VIRT_COUNT > 1) ? $clog2(VIRT_COUNT) : 1;
  localparam int SLOT_COUNT = PHYS_X * PHYS_Y * PHYS_Z;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PX_W = (PHYS_X > 1) ? $clog2(PHYS_X) : 1;
  localparam int PY_W = (PHYS_Y > 1) ? $clog2(PHYS_Y) : 1;
  localparam int PZ_W = (PHYS_Z > 1) ? $clog2(PHYS_Z) : 1;
  localparam int CW = vbpt_pkg::COORD_W;
  localparam int BW = vbpt_pkg::BSIZE_W;

  typedef struct packed {
    logic            written;
    logic [PZ_W-1:0] z;
    logic [PY_W-1:0] y;
    logic [PX_W-1:0] x;
  } slot_entry_t;

  typedef enum logic [3:0] {
    S_CLEAR   = 4'b0001,
    S_IDLE    = 4'b0010,
    S_READ    = 4'b0100,
    S_RESOLVE = 4'b1000
  } state_t;

  // Memories
  slot_entry_t      slot_mem   [VIRT_COUNT];
  logic             mapped_mem [VIRT_COUNT];
  logic [LIN_W-1:0] owner_mem  [SLOT_COUNT];

  slot_entry_t      slot_rd_r;
  logic             mapped_rd_r;
  logic [LIN_W-1:0] owner_rd_r;

  logic             slot_we;
  logic [LIN_W-1:0] slot_waddr;
  slot_entry_t      slot_wdata;
  logic             mapped_we;
  logic [LIN_W-1:0] mapped_waddr;
  logic             mapped_wdata;
  logic             owner_we;

  state_t           state_r, state_nxt;
  logic [LIN_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             cur_cmd_r, cur_cmd_nxt;
  logic [LIN_W-1:0] cur_lin_r, cur_lin_nxt;

  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [PX_W-1:0]   px_r, px_nxt;
  logic [PY_W-1:0]   py_r, py_nxt;
  logic [PZ_W-1:0]   pz_r, pz_nxt;
  logic              wrapped_r, wrapped_nxt;

  logic        res_valid_r, res_valid_nxt;
  slot_entry_t res_entry_r, res_entry_nxt;
  logic        res_mapped_r, res_mapped_nxt;

  logic       out_valid_r;
  vbpt_pkg::out_item_t out_data_r, out_data_nxt;

  function automatic logic [CW-1:0] scale_coord(input logic [5:0] idx,
                                                input logic [BW-1:0] bs);
    logic [BW+5:0] p;
    p = {{BW{1'b0}}, idx} * {6'd0, bs};
    if (p > (BW+6)'(2047)) return CW'(2047);
    return p[CW-1:0];
  endfunction

  assign clearing  = (state_r == S_CLEAR);
  assign q_pop     = ((state_r == S_IDLE) || (state_r == S_RESOLVE)) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer and memory port control
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_cmd_nxt    = cur_cmd_r;
    cur_lin_nxt    = cur_lin_r;
    ptr_nxt        = ptr_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    pz_nxt         = pz_r;
    wrapped_nxt    = wrapped_r;
    res_valid_nxt  = 1'b0;
    res_entry_nxt  = res_entry_r;
    res_mapped_nxt = res_mapped_r;
    slot_we        = 1'b0;
    slot_waddr     = cur_lin_r;
    slot_wdata     = '{written: 1'b1, z: pz_r, y: py_r, x: px_r};
    mapped_we      = 1'b0;
    mapped_waddr   = cur_lin_r;
    mapped_wdata   = 1'b1;
    owner_we       = 1'b0;

    if (q_pop) begin
      cur_cmd_nxt = q_rdata[LIN_W];
      cur_lin_nxt = q_rdata[LIN_W-1:0];
    end

    case (state_r)
      S_CLEAR: begin
        slot_we      = 1'b1;
        slot_waddr   = clr_cnt_r;
        slot_wdata   = '0;
        mapped_we    = 1'b1;
        mapped_waddr = clr_cnt_r;
        mapped_wdata = 1'b0;
        clr_cnt_nxt  = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LIN_W'(VIRT_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_pop) state_nxt = S_READ;
      end
      S_READ: begin
        // Map: claim the entry now, owner word comes back next cycle
        if (cur_cmd_r == vbpt_pkg::CMD_MAP) begin
          slot_we   = 1'b1;
          mapped_we = 1'b1;
        end
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        res_valid_nxt = 1'b1;
        if (cur_cmd_r == vbpt_pkg::CMD_MAP) begin
          owner_we       = 1'b1;
          res_entry_nxt  = '{written: 1'b1, z: pz_r, y: py_r, x: px_r};
          res_mapped_nxt = !(wrapped_r && (owner_rd_r == cur_lin_r));
          // Drop the previous owner's mapped flag
          if (wrapped_r) begin
            mapped_we    = 1'b1;
            mapped_waddr = owner_rd_r;
            mapped_wdata = 1'b0;
          end
          // Step the replacement pointer down, wrap to the last slot
          wrapped_nxt = wrapped_r | (ptr_r == '0);
          ptr_nxt = (ptr_r == '0) ? SLOT_W'(SLOT_COUNT - 1) : ptr_r - 1'b1;
          if (px_r == '0) begin
            px_nxt = PX_W'(PHYS_X - 1);
            if (py_r == '0) begin
              py_nxt = PY_W'(PHYS_Y - 1);
              pz_nxt = (pz_r == '0) ? PZ_W'(PHYS_Z - 1) : pz_r - 1'b1;
            end else begin
              py_nxt = py_r - 1'b1;
            end
          end else begin
            px_nxt = px_r - 1'b1;
          end
        end else begin
          res_entry_nxt  = slot_rd_r;
          res_mapped_nxt = mapped_rd_r;
        end
        state_nxt = q_pop ? S_READ : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output stage: scale slot coordinates by the block size, or -1 if unwritten
  always_comb begin
    if (res_entry_r.written) begin
      out_data_nxt.phys_x = scale_coord(6'(res_entry_r.x), bsize.x);
      out_data_nxt.phys_y = scale_coord(6'(res_entry_r.y), bsize.y);
      out_data_nxt.phys_z = scale_coord(6'(res_entry_r.z), bsize.z);
    end else begin
      out_data_nxt.phys_x = '1;
      out_data_nxt.phys_y = '1;
      out_data_nxt.phys_z = '1;
    end
    out_data_nxt.is_mapped = res_mapped_r;
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rd_r <= slot_mem[cur_lin_r];
  end

  always_ff @(posedge clk) begin
    if (mapped_we) mapped_mem[mapped_waddr] <= mapped_wdata;
    mapped_rd_r <= mapped_mem[cur_lin_r];
  end

  always_ff @(posedge clk) begin
    if (owner_we) owner_mem[ptr_r] <= cur_lin_r;
    owner_rd_r <= owner_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      ptr_r       <= SLOT_W'(SLOT_COUNT - 1);
      px_r        <= PX_W'(PHYS_X - 1);
      py_r        <= PY_W'(PHYS_Y - 1);
      pz_r        <= PZ_W'(PHYS_Z - 1);
      wrapped_r   <= 1'b0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ptr_r       <= ptr_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      pz_r        <= pz_nxt;
      wrapped_r   <= wrapped_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= res_valid_r;
    end
    cur_cmd_r    <= cur_cmd_nxt;
    cur_lin_r    <= cur_lin_nxt;
    res_entry_r  <= res_entry_nxt;
    res_mapped_r <= res_mapped_nxt;
    out_data_r   <= out_data_nxt;
  end

  `VBPT_ASSERT_NEXT(a_one_result_per_item, clk, rst_n, res_valid_r, !res_valid_r,
    "back produced results in two consecutive cycles")
  `VBPT_ASSERT_NOW(a_ptr_coords_agree, clk, rst_n, 1'b1,
    32'(ptr_r) == 32'(px_r) + PHYS_X * (32'(py_r) + PHYS_Y * 32'(pz_r)),
    "replacement pointer and its slot coordinates disagree")
  `VBPT_ASSERT_NEXT(a_read_then_resolve, clk, rst_n, state_r == S_READ,
    state_r == S_RESOLVE, "read phase not followed by resolve phase")
  `VBPT_ASSERT_NOW(a_no_pop_while_clearing, clk, rst_n, state_r == S_CLEAR, !q_pop,
    "item taken from queue during clearing pass")

endmodule

/* rtl/core/volume_block_page_table_core.sv */
// Page table for a virtual 3D volume backed by a cache of physical block slots.
// Input channel: present a command on in_data with start high; the transaction
// is taken at a rising edge where start is high and busy is low. A map command
// gives the slot under the round-robin replacement pointer to the block and
// unmaps that slot's previous owner; a lookup returns the block's entry as is.
// Configuration: cfg_we writes cfg_data into block size register cfg_index
// (0 x, 1 y, 2 z) at the clock edge; write only while no transaction is open.
// Result channel: out_valid is high for one cycle with out_data holding voxel
// coordinates of the slot (-1 if never mapped) and the mapped flag. The
// receiver cannot hold results off, and none is needed: results leave the
// output register in order, one per transaction.
// An accepted transaction passes the front end's holding register, the queue,
// the back end's read and resolve states, its result register and the output
// register; the back end pops the next one while resolving. A two-entry queue
// between front end and back end absorbs bursts; busy rises once the queue
// and the front end's holding register are both full.
// Reset: rst_n synchronous, active low. After reset the page table is cleared
// one entry per cycle, all VIRT_X*VIRT_Y*VIRT_Z entries (32768 by default),
// with busy held high; configuration writes are taken during that pass.
module volume_block_page_table_core #(
  parameter int VIRT_X = 32,
  parameter int VIRT_Y = 32,
  parameter int VIRT_Z = 32,
  parameter int PHYS_X = 8,
  parameter int PHYS_Y = 8,
  parameter int PHYS_Z = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  vbpt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  output vbpt_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [vbpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vbpt_pkg::BSIZE_W-1:0]        cfg_data
);

  localparam int VIRT_COUNT = VIRT_X * VIRT_Y * VIRT_Z;
  localparam int LIN_W = (VIRT_COUNT > 1) ? $clog2(VIRT_COUNT) : 1;

  vbpt_pkg::block_size_t bsize_r, bsize_nxt;

  logic           accept;
  logic           front_stall;
  logic           back_clearing;
  logic           q_push, q_pop, q_full, q_empty;
  logic [LIN_W:0] q_wdata, q_rdata;

  // Hold off new transactions while clearing or while the front end is blocked.
  assign busy   = back_clearing || front_stall;
  assign accept = start && !busy;

  // Block size registers; an index beyond the list is dropped.
  always_comb begin
    bsize_nxt = bsize_r;
    if (cfg_we) begin
      case (cfg_index)
        vbpt_pkg::CFG_BLOCK_SIZE_X: bsize_nxt.x = cfg_data;
        vbpt_pkg::CFG_BLOCK_SIZE_Y: bsize_nxt.y = cfg_data;
        vbpt_pkg::CFG_BLOCK_SIZE_Z: bsize_nxt.z = cfg_data;
        default: bsize_nxt = bsize_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= '{x: vbpt_pkg::BSIZE_RESET, y: vbpt_pkg::BSIZE_RESET,
                   z: vbpt_pkg::BSIZE_RESET};
    end else begin
      bsize_r <= bsize_nxt;
    end
  end

  // Front end: saturate indexes, linearize, hand over to the queue.
  vbpt_front #(
    .VIRT_X (VIRT_X),
    .VIRT_Y (VIRT_Y),
    .VIRT_Z (VIRT_Z)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .stall   (front_stall)
  );

  vbpt_queue #(
    .WIDTH (LIN_W + 1)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back end: page table, owner table, replacement pointer, output scaling.
  vbpt_back #(
    .VIRT_COUNT (VIRT_COUNT),
    .PHYS_X     (PHYS_X),
    .PHYS_Y     (PHYS_Y),
    .PHYS_Z     (PHYS_Z)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .bsize     (bsize_r),
    .clearing  (back_clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
